// File: hw/rtl/lfga_pkg.sv
// Shared constants and types for the lowest-free-gate allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lfga_pkg;

   localparam int TimeWidth      = 32;
   localparam int GateCfgWidth   = 5;
   localparam int GateNumWidth   = 4;
   localparam int NumGatesDefault = 16;
   localparam logic [GateCfgWidth-1:0] GatesInUseReset = 5'd16;

   typedef logic [TimeWidth-1:0] time_type;

   typedef struct packed {
      logic                    accepted;
      logic [GateNumWidth-1:0] gate_number;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/lfga_release_mem.sv
// Release-time store: one 32-bit time per gate, one write and one read port,
// registered read data. Depends on lfga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfga_release_mem #(
   parameter int Depth = 16,
   parameter int AddrWidth = 4
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [AddrWidth-1:0]      wr_addr,
   input  wire  lfga_pkg::time_type  wr_data,
   input  wire  [AddrWidth-1:0]      rd_addr,
   output lfga_pkg::time_type        rd_data
);
   import lfga_pkg::*;

   time_type mem_ff [Depth];
   time_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lfga_scan.sv
// Scan sequencer: walks the gates one per cycle with a single compare unit,
// keeps the occupied bits and the result register. Depends on lfga_pkg
// and lfga_release_mem.
`timescale 1ns / 1ps
`default_nettype none

module lfga_scan #(
   parameter int NumGates = 16,
   parameter int IdxWidth = 4,
   parameter int CntWidth = 5
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [CntWidth-1:0]        limit,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  lfga_pkg::time_type   req_start_time,
   input  wire  lfga_pkg::time_type   req_end_time,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output lfga_pkg::result_type       rsp_word
);
   import lfga_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic [CntWidth-1:0]   limit_ff, limit_in;
   time_type              start_ff, start_in;
   time_type              end_ff, end_in;
   logic                  hit_ff, hit_in;
   logic [NumGates-1:0]   occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic                  mem_we;
   logic [IdxWidth-1:0]   rd_addr;
   time_type              rd_data;
   logic                  gate_free;
   logic                  last_gate;
   logic                  out_free;
   logic                  decide;
   logic                  commit;
   logic                  commit_hit;

   lfga_release_mem #(
      .Depth     (NumGates),
      .AddrWidth (IdxWidth)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_ff),
      .wr_data (end_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rd_data is registered behind the address, so fetch the next gate ahead
   assign rd_addr   = (state_ff == ST_IDLE) ? '0 : idx_ff + 1'b1;
   assign gate_free = (limit_ff != '0) && (!occ_ff[idx_ff] || (rd_data < start_ff));
   assign last_gate = (limit_ff == '0) || ((CntWidth'(idx_ff) + 1'b1) == limit_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign decide    = (state_ff == ST_SCAN) && (gate_free || last_gate);
   assign commit    = ((state_ff == ST_HOLD) || decide) && out_free;
   assign commit_hit = (state_ff == ST_HOLD) ? hit_ff : gate_free;
   assign mem_we    = commit && commit_hit;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      limit_in     = limit_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      hit_in       = hit_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (commit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.accepted      = commit_hit;
         rsp_in.gate_number   = commit_hit ? GateNumWidth'(idx_ff) : '0;
         if (commit_hit) begin
            occ_in[idx_ff] = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               limit_in = limit;
               start_in = req_start_time;
               end_in   = req_end_time;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (decide) begin
               hit_in   = gate_free;
               state_in = commit ? ST_IDLE : ST_HOLD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      limit_ff <= limit_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      hit_ff   <= hit_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lowest_free_gate_allocator.sv
// Lowest-free-gate allocator, top level.
// Each accepted request scans the gates from gate 0 upward and is granted the
// lowest free gate below limit (limit = gates in use), else it is rejected.
// One request at a time: a new one is taken only once the last result is
// registered; one release-time compare per cycle through the single read port of the store.
// Reset: all gates unoccupied, gates_in_use = 16, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_gate_allocator #(
   parameter int NumGates = lfga_pkg::NumGatesDefault
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      csr_write_enable,
   input  wire  [lfga_pkg::GateCfgWidth-1:0]        csr_gates_in_use,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire  [lfga_pkg::TimeWidth-1:0]           req_start_time,
   input  wire  [lfga_pkg::TimeWidth-1:0]           req_end_time,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic                                     rsp_accepted,
   output logic [lfga_pkg::GateNumWidth-1:0]        rsp_gate_number
);
   import lfga_pkg::*;

   localparam int IdxWidth  = (NumGates > 1) ? $clog2(NumGates) : 1;
   localparam int CntRaw    = $clog2(NumGates + 1);
   localparam int CntWidth  = (CntRaw > GateCfgWidth) ? CntRaw : GateCfgWidth;

   logic [GateCfgWidth-1:0] gates_ff, gates_in;
   logic [CntWidth-1:0]     gates_wide;
   logic [CntWidth-1:0]     limit;
   result_type              rsp_word;

   assign gates_in = csr_write_enable ? csr_gates_in_use : gates_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gates_ff <= GatesInUseReset;
      end else begin
         gates_ff <= gates_in;
      end
   end

   // clamp the register to the gates actually built
   assign gates_wide = CntWidth'(gates_ff);
   assign limit = (gates_wide > CntWidth'(NumGates)) ? CntWidth'(NumGates) : gates_wide;

   lfga_scan #(
      .NumGates (NumGates),
      .IdxWidth (IdxWidth),
      .CntWidth (CntWidth)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .limit          (limit),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word)
   );

   assign rsp_accepted    = rsp_word.accepted;
   assign rsp_gate_number = rsp_word.gate_number;

endmodule

`default_nettype wire
